[hw/rtl/rfe_pkg.sv]
// shared types, constants and frame-building functions for the remote frame encoder
`default_nettype none

package rfe_pkg;

   localparam int FrameBytes   = 23;
   localparam int FrameBits    = FrameBytes * 8;
   localparam int WordBits     = 13;
   localparam int CodedBits    = 2 * WordBits;
   localparam int WordCount    = 7;
   localparam int PadBits      = FrameBits - WordCount * CodedBits;
   localparam int ByteIdxBits  = $clog2(FrameBytes);
   localparam int SerialBits   = 24;
   localparam int QueueDepth   = 2;
   localparam int QueuePtrBits = $clog2(QueueDepth);

   localparam logic [2:0]  LevelMax   = 3'd6;
   localparam logic [3:0]  Chk1C      = 4'hD;
   localparam logic [3:0]  Chk1D      = 4'h0;
   localparam logic [3:0]  Chk2C      = 4'h0;
   localparam logic [3:0]  Chk2D      = 4'h7;
   localparam logic [12:0] WordMark   = 13'h1000;
   localparam logic [12:0] Word0Extra = 13'h0200;

   localparam logic [ByteIdxBits-1:0] LastByte = ByteIdxBits'(FrameBytes - 1);

   typedef logic [FrameBits-1:0] frame_type;

   typedef struct packed {
      logic      valid;
      frame_type bits;
   } frame_xfer_type;

   function automatic logic [2:0] clamp_level(input logic [2:0] v);
      return (v > LevelMax) ? LevelMax : v;
   endfunction

   function automatic logic [7:0] nibble_check(input logic [7:0] b, input logic [3:0] c,
                                               input logic [3:0] d);
      logic [3:0] h;
      logic [3:0] l;
      logic [3:0] x;
      logic [3:0] y;
      h = b[7:4];
      l = b[3:0];
      x = c ^ {h[2:0], 1'b0} ^ h ^ {l[2:0], 1'b0};
      y = d ^ h ^ l;
      return {x, y};
   endfunction

   function automatic logic [12:0] make_word(input logic [7:0] d, input logic p);
      return WordMark | {2'b00, d, 3'b000} | {11'b0, p, 1'b0} | 13'h0001;
   endfunction

   // top bit of a word always codes as 11, then 1 -> 10 and 0 -> 01
   function automatic logic [CodedBits-1:0] line_code(input logic [WordBits-1:0] w);
      logic [CodedBits-1:0] c;
      c = '0;
      c[CodedBits-1 -: 2] = 2'b11;
      for (int i = 0; i < WordBits - 1; i++) begin
         c[2*i +: 2] = w[i] ? 2'b10 : 2'b01;
      end
      return c;
   endfunction

endpackage

`default_nettype wire

[hw/rtl/rfe_front.sv]
// front end: serial register, command packing, checksums and frame line coding
`default_nettype none

module rfe_front
   import rfe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [SerialBits-1:0] csr_write_data,
   input  wire logic                  req_push,
   input  wire logic                  queue_full,
   input  wire logic                  req_power,
   input  wire logic                  req_thermostat,
   input  wire logic                  req_pilot_cpi,
   input  wire logic [2:0]            req_light_level,
   input  wire logic [2:0]            req_fan_level,
   input  wire logic [2:0]            req_flame_level,
   input  wire logic                  req_aux_power,
   input  wire logic                  req_secondary_flame,
   output frame_xfer_type             frame_out
);

   logic [SerialBits-1:0] serial_ff;
   logic [SerialBits-1:0] serial_in;

   logic [7:0]  s1, s2, s3, cmd1, cmd2, chk1, chk2;
   logic [12:0] w0, w1, w2, w3, w4, w5, w6;

   always_comb begin
      serial_in = csr_write_enable ? csr_write_data : serial_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         serial_ff <= '0;
      end else begin
         serial_ff <= serial_in;
      end
   end

   always_comb begin
      s1   = serial_ff[23:16];
      s2   = serial_ff[15:8];
      s3   = serial_ff[7:0];
      cmd1 = {req_pilot_cpi, clamp_level(req_light_level), 2'b00, req_thermostat, req_power};
      cmd2 = {req_secondary_flame, clamp_level(req_fan_level), req_aux_power,
              clamp_level(req_flame_level)};
      chk1 = nibble_check(cmd1, Chk1C, Chk1D);
      chk2 = nibble_check(cmd2, Chk2C, Chk2D);
      // first word carries an extra mark bit and inverted parity
      w0   = make_word(s1, ~(^s1)) | Word0Extra;
      w1   = make_word(s2, ^s2);
      w2   = make_word(s3, ^s3);
      w3   = make_word(cmd1, ^cmd1);
      w4   = make_word(cmd2, ^cmd2);
      w5   = make_word(chk1, ^chk1);
      w6   = make_word(chk2, ^chk2);
   end

   always_comb begin
      frame_out.valid = req_push && !queue_full;
      frame_out.bits  = {line_code(w0), line_code(w1), line_code(w2), line_code(w3),
                         line_code(w4), line_code(w5), line_code(w6), {PadBits{1'b0}}};
   end

endmodule

`default_nettype wire

[hw/rtl/rfe_queue.sv]
// two-entry frame queue between the front end and the byte serializer
`default_nettype none

module rfe_queue
   import rfe_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire frame_xfer_type wr,
   output logic               full,
   input  wire logic          rd_take,
   output frame_xfer_type     rd
);

   frame_type                 entry_ff [QueueDepth];
   logic [QueuePtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrBits:0]     count_ff, count_in;
   logic                      do_wr, do_rd;

   always_comb begin
      full     = (count_ff == (QueuePtrBits+1)'(QueueDepth));
      rd.valid = (count_ff != '0);
      rd.bits  = entry_ff[rd_ptr_ff];
      do_wr    = wr.valid && !full;
      do_rd    = rd_take && rd.valid;
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QueuePtrBits+1)'(do_wr) - (QueuePtrBits+1)'(do_rd);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr.bits;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/rfe_back.sv]
// back end: holds one frame, a byte per cycle into the output register unless stalled
`default_nettype none

module rfe_back
   import rfe_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire frame_xfer_type q_in,
   output logic                q_take,
   output logic                rsp_empty,
   input  wire logic           rsp_pop,
   output logic [7:0]          rsp_encoded_byte,
   output logic                rsp_last
);

   frame_type              frame_ff, frame_in;
   logic                   loaded_ff, loaded_in;
   logic [ByteIdxBits-1:0] idx_ff, idx_in;
   logic                   out_valid_ff, out_valid_in;
   logic [7:0]             out_byte_ff, out_byte_in;
   logic                   out_last_ff, out_last_in;
   logic                   advance;
   logic                   at_last;
   logic [ByteIdxBits-1:0] byte_sel;

   always_comb begin
      advance  = !out_valid_ff || rsp_pop;
      at_last  = (idx_ff == LastByte);
      // the next frame loads in the same cycle its predecessor's final byte moves out
      q_take   = q_in.valid && (!loaded_ff || (advance && at_last));
      byte_sel = LastByte - idx_ff;

      frame_in  = frame_ff;
      loaded_in = loaded_ff;
      idx_in    = idx_ff;
      if (q_take) begin
         frame_in  = q_in.bits;
         loaded_in = 1'b1;
         idx_in    = '0;
      end else if (advance && loaded_ff) begin
         if (at_last) begin
            loaded_in = 1'b0;
         end else begin
            idx_in = idx_ff + 1'b1;
         end
      end

      out_valid_in = out_valid_ff;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (advance) begin
         out_valid_in = loaded_ff;
         out_byte_in  = frame_ff[{byte_sel, 3'b000} +: 8];
         out_last_in  = at_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff    <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         loaded_ff    <= loaded_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frame_ff    <= frame_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   always_comb begin
      rsp_empty        = !out_valid_ff;
      rsp_encoded_byte = out_byte_ff;
      rsp_last         = out_last_ff;
   end

endmodule

`default_nettype wire

[hw/rtl/remote_frame_encoder.sv]
// remote frame encoder: command in, 23 line-coded frame bytes out
// first byte path when idle: queue entry, serializer frame register, output register
// throughput: one byte per cycle unless the receiver stalls, so one command per 23
//   bytes sustained, set by the single byte-wide output register of the serializer
// a two-entry frame queue plus the serializer's frame register let commands run ahead
// reset (synchronous, active high) clears the serial register, queue and output
`default_nettype none

module remote_frame_encoder
   import rfe_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_write_enable,
   input  wire logic [SerialBits-1:0] csr_write_data,
   input  wire logic                  req_push,
   output logic                       req_full,
   input  wire logic                  req_power,
   input  wire logic                  req_thermostat,
   input  wire logic                  req_pilot_cpi,
   input  wire logic [2:0]            req_light_level,
   input  wire logic [2:0]            req_fan_level,
   input  wire logic [2:0]            req_flame_level,
   input  wire logic                  req_aux_power,
   input  wire logic                  req_secondary_flame,
   output logic                       rsp_empty,
   input  wire logic                  rsp_pop,
   output logic [7:0]                 rsp_encoded_byte,
   output logic                       rsp_last
);

   frame_xfer_type front_frame;
   frame_xfer_type queue_head;
   logic           queue_full;
   logic           queue_take;

   rfe_front u_front (
      .clock               (clock),
      .reset               (reset),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .req_push            (req_push),
      .queue_full          (queue_full),
      .req_power           (req_power),
      .req_thermostat      (req_thermostat),
      .req_pilot_cpi       (req_pilot_cpi),
      .req_light_level     (req_light_level),
      .req_fan_level       (req_fan_level),
      .req_flame_level     (req_flame_level),
      .req_aux_power       (req_aux_power),
      .req_secondary_flame (req_secondary_flame),
      .frame_out           (front_frame)
   );

   rfe_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr      (front_frame),
      .full    (queue_full),
      .rd_take (queue_take),
      .rd      (queue_head)
   );

   rfe_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_in             (queue_head),
      .q_take           (queue_take),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_encoded_byte (rsp_encoded_byte),
      .rsp_last         (rsp_last)
   );

   assign req_full = queue_full;

endmodule

`default_nettype wire

[hw/rtl/rfe_checker.sv]
// port-level checker for the remote frame encoder and its bind
`default_nettype none

module rfe_checker
   import rfe_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_empty,
   input wire logic       rsp_pop,
   input wire logic [7:0] rsp_encoded_byte,
   input wire logic       rsp_last
);

   logic [ByteIdxBits-1:0] cnt_ff, cnt_in;
   logic                   rsp_xfer;

   always_comb begin
      rsp_xfer = rsp_pop && !rsp_empty;
      cnt_in   = cnt_ff;
      if (rsp_xfer) begin
         cnt_in = (cnt_ff == LastByte) ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result side not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_encoded_byte)
                                    && $stable(rsp_last)))
      else $error("stalled result changed");

   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_last == (cnt_ff == LastByte)))
      else $error("last flag not on the final byte of a frame");

   a_frame_start: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && cnt_ff == '0) |-> (rsp_encoded_byte[7:6] == 2'b11))
      else $error("frame does not open with the word start mark");

   a_pad: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_last) |-> (rsp_encoded_byte[1:0] == 2'b00))
      else $error("pad bits of the final byte not zero");

endmodule

bind remote_frame_encoder rfe_checker u_rfe_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_empty        (rsp_empty),
   .rsp_pop          (rsp_pop),
   .rsp_encoded_byte (rsp_encoded_byte),
   .rsp_last         (rsp_last)
);

`default_nettype wire

[tb/frame_checker.sv]
// frame checker for the remote frame encoder: predicts each frame and compares it byte by byte
module frame_checker
   import rfe_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [SerialBits-1:0] csr_write_data,
   input  logic                  req_push,
   input  logic                  req_full,
   input  logic                  req_power,
   input  logic                  req_thermostat,
   input  logic                  req_pilot_cpi,
   input  logic [2:0]            req_light_level,
   input  logic [2:0]            req_fan_level,
   input  logic [2:0]            req_flame_level,
   input  logic                  req_aux_power,
   input  logic                  req_secondary_flame,
   input  logic                  rsp_empty,
   input  logic                  rsp_pop,
   input  logic [7:0]            rsp_encoded_byte,
   input  logic                  rsp_last,
   output int                    mismatches,
   output int                    outstanding,
   output int                    bytes_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [7:0] code;
      logic       last;
   } coded_byte_t;

   coded_byte_t           expected_bytes[$];
   logic [SerialBits-1:0] serial_copy;
   int                    error_count;
   int                    compared;

   initial begin
      error_count   = 0;
      compared      = 0;
      serial_copy   = '0;
   end

   function automatic logic [7:0] check_byte(input logic [7:0] b, input logic [3:0] c,
                                             input logic [3:0] d);
      logic [3:0] hi;
      logic [3:0] lo;
      hi = b[7:4];
      lo = b[3:0];
      return {c ^ (hi << 1) ^ hi ^ (lo << 1), d ^ hi ^ lo};
   endfunction

   function automatic logic [FrameBits-1:0] encode_frame(
      input logic [SerialBits-1:0] serial,
      input logic power, input logic thermostat, input logic pilot,
      input logic [2:0] light_in, input logic [2:0] fan_in, input logic [2:0] flame_in,
      input logic aux, input logic secondary);
      logic [2:0]           light;
      logic [2:0]           fan;
      logic [2:0]           flame;
      logic [7:0]           cmd1;
      logic [7:0]           cmd2;
      logic [7:0]           data[WordCount];
      logic [12:0]          word;
      logic                 par;
      logic [FrameBits-1:0] bits;
      int                   pos;
      light = (light_in > LevelMax) ? LevelMax : light_in;
      fan   = (fan_in > LevelMax) ? LevelMax : fan_in;
      flame = (flame_in > LevelMax) ? LevelMax : flame_in;
      cmd1 = {pilot, light, 2'b00, thermostat, power};
      cmd2 = {secondary, fan, aux, flame};
      data[0] = serial[23:16];
      data[1] = serial[15:8];
      data[2] = serial[7:0];
      data[3] = cmd1;
      data[4] = cmd2;
      data[5] = check_byte(cmd1, Chk1C, Chk1D);
      data[6] = check_byte(cmd2, Chk2C, Chk2D);
      bits = '0;
      pos  = 0;
      for (int w = 0; w < WordCount; w++) begin
         // first word carries the extra marker bit and inverted parity
         par  = (w == 0) ? ~(^data[w]) : ^data[w];
         word = WordMark | {2'b00, data[w], 3'b000} | {11'b0, par, 1'b0} | 13'h0001;
         if (w == 0) word = word | Word0Extra;
         for (int b = WordBits - 1; b >= 0; b--) begin
            if (b == WordBits - 1) begin
               bits[FrameBits-1-pos] = 1'b1;
               bits[FrameBits-2-pos] = 1'b1;
            end else if (word[b]) begin
               bits[FrameBits-1-pos] = 1'b1;
            end else begin
               bits[FrameBits-2-pos] = 1'b1;
            end
            pos += 2;
         end
      end
      return bits;
   endfunction

   always @(posedge clock) begin
      logic [FrameBits-1:0] frame;
      coded_byte_t          want;
      if (reset) begin
         expected_bytes.delete();
         serial_copy = '0;
      end else begin
         if (csr_write_enable) serial_copy = csr_write_data;
         if (req_push && !req_full) begin
            frame = encode_frame(serial_copy, req_power, req_thermostat, req_pilot_cpi,
                                 req_light_level, req_fan_level, req_flame_level,
                                 req_aux_power, req_secondary_flame);
            for (int k = 0; k < FrameBytes; k++) begin
               expected_bytes.push_back({frame[FrameBits-1-8*k -: 8], k == FrameBytes - 1});
            end
         end
         if (rsp_pop && !rsp_empty) begin
            compared++;
            if (expected_bytes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected byte transfer, got byte %02h last %0d",
                        $time, rsp_encoded_byte, rsp_last);
            end else begin
               want = expected_bytes.pop_front();
               if (want.code !== rsp_encoded_byte) begin
                  error_count++;
                  $display("%0t: encoded_byte mismatch, expected %02h, got %02h",
                           $time, want.code, rsp_encoded_byte);
               end
               if (want.last !== rsp_last) begin
                  error_count++;
                  $display("%0t: last mismatch, expected %0d, got %0d",
                           $time, want.last, rsp_last);
               end
            end
         end
      end
      // registered so the stimulus side reads a settled value
      mismatches    <= error_count;
      outstanding   <= expected_bytes.size();
      bytes_checked <= compared;
   end

endmodule

[tb/testbench.sv]
// top of the remote frame encoder testbench: clock, reset, commands, serial writes, verdict
module testbench;
   import rfe_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock               = 1'b0;
   logic                  reset               = 1'b1;
   logic                  csr_write_enable    = 1'b0;
   logic [SerialBits-1:0] csr_write_data      = '0;
   logic                  req_push            = 1'b0;
   logic                  req_full;
   logic                  req_power           = 1'b0;
   logic                  req_thermostat      = 1'b0;
   logic                  req_pilot_cpi       = 1'b0;
   logic [2:0]            req_light_level     = '0;
   logic [2:0]            req_fan_level       = '0;
   logic [2:0]            req_flame_level     = '0;
   logic                  req_aux_power       = 1'b0;
   logic                  req_secondary_flame = 1'b0;
   logic                  rsp_empty;
   logic                  rsp_pop             = 1'b0;
   logic [7:0]            rsp_encoded_byte;
   logic                  rsp_last;

   int mismatches;
   int outstanding;
   int bytes_checked;
   int push_idle_pct = 0;
   int pop_idle_pct  = 0;
   int commands_sent = 0;
   int serial_writes = 0;

   always #5 clock = ~clock;

   remote_frame_encoder dut (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_power          (req_power),
      .req_thermostat     (req_thermostat),
      .req_pilot_cpi      (req_pilot_cpi),
      .req_light_level    (req_light_level),
      .req_fan_level      (req_fan_level),
      .req_flame_level    (req_flame_level),
      .req_aux_power      (req_aux_power),
      .req_secondary_flame(req_secondary_flame),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_encoded_byte   (rsp_encoded_byte),
      .rsp_last           (rsp_last)
   );

   frame_checker u_checker (
      .clock              (clock),
      .reset              (reset),
      .csr_write_enable   (csr_write_enable),
      .csr_write_data     (csr_write_data),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_power          (req_power),
      .req_thermostat     (req_thermostat),
      .req_pilot_cpi      (req_pilot_cpi),
      .req_light_level    (req_light_level),
      .req_fan_level      (req_fan_level),
      .req_flame_level    (req_flame_level),
      .req_aux_power      (req_aux_power),
      .req_secondary_flame(req_secondary_flame),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_encoded_byte   (rsp_encoded_byte),
      .rsp_last           (rsp_last),
      .mismatches         (mismatches),
      .outstanding        (outstanding),
      .bytes_checked      (bytes_checked)
   );

   // receiver side: random stalls at the current rate
   always @(posedge clock) begin
      rsp_pop <= reset ? 1'b0 : ($urandom_range(0, 99) >= pop_idle_pct);
   end

   task automatic send_cmd(input logic power, input logic thermostat, input logic pilot,
                           input logic [2:0] light, input logic [2:0] fan,
                           input logic [2:0] flame, input logic aux, input logic secondary);
      while ($urandom_range(0, 99) < push_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push            <= 1'b1;
      req_power           <= power;
      req_thermostat      <= thermostat;
      req_pilot_cpi       <= pilot;
      req_light_level     <= light;
      req_fan_level       <= fan;
      req_flame_level     <= flame;
      req_aux_power       <= aux;
      req_secondary_flame <= secondary;
      do @(posedge clock); while (req_full);
      commands_sent++;
   endtask

   task automatic send_random_cmd();
      send_cmd(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
   endtask

   // stop sending and wait until every predicted byte has been transferred
   task automatic drain_frames();
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_serial(input logic [SerialBits-1:0] value);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      serial_writes++;
   endtask

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_idle_pct = 25;
      pop_idle_pct  = 51;
      write_serial(24'hFFFFFF);

      // directed: field extremes, every level value including the clamped one
      send_cmd(1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0);
      send_cmd(1'b1, 1'b1, 1'b1, 3'd7, 3'd7, 3'd7, 1'b1, 1'b1);
      send_cmd(1'b1, 1'b1, 1'b1, 3'd6, 3'd6, 3'd6, 1'b1, 1'b1);
      send_cmd(1'b1, 1'b0, 1'b0, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0);
      send_cmd(1'b0, 1'b1, 1'b0, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0);
      send_cmd(1'b0, 1'b0, 1'b1, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0);
      send_cmd(1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 3'd0, 1'b1, 1'b0);
      send_cmd(1'b0, 1'b0, 1'b0, 3'd0, 3'd0, 3'd0, 1'b0, 1'b1);
      for (int lvl = 0; lvl < 8; lvl++) begin
         send_cmd(lvl[0], lvl[1], lvl[2], 3'(lvl), 3'(7 - lvl), 3'(lvl + 3),
                  ~lvl[0], ~lvl[1]);
      end
      drain_frames();
      write_serial(24'h000000);
      send_cmd(1'b0, 1'b0, 1'b0, 3'd7, 3'd0, 3'd7, 1'b0, 1'b0);
      send_cmd(1'b1, 1'b1, 1'b1, 3'd0, 3'd7, 3'd0, 1'b1, 1'b1);
      drain_frames();

      write_serial(24'h000000);
      for (int i = 0; i < 60; i++) begin
         if (i == 30) drain_frames();
         send_random_cmd();
      end
      drain_frames();

      push_idle_pct = 51;
      pop_idle_pct  = 25;
      write_serial(24'($urandom_range(0, 24'hFFFFFF)));
      for (int i = 0; i < 60; i++) send_random_cmd();
      drain_frames();

      push_idle_pct = 0;
      pop_idle_pct  = 0;
      write_serial(24'($urandom_range(0, 24'hFFFFFF)));
      for (int i = 0; i < 60; i++) send_random_cmd();
      drain_frames();
      repeat (10) @(posedge clock);

      $display("covered %0d commands under %0d serial numbers, %0d frame bytes compared",
               commands_sent, serial_writes, bytes_checked);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
